// File: design/bb3c_pkg.sv
package bb3c_pkg;

  localparam int CHAN_W     = 16;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int RESET_SIZE = 64;

  // Result slots of one input pixel, in delivery order
  localparam int EMIT_UP_LEFT = 0;
  localparam int EMIT_UP      = 1;
  localparam int EMIT_LEFT    = 2;
  localparam int EMIT_HERE    = 3;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_kind_t;

  typedef struct packed {
    logic [3:0] emit;
    logic       col_ge2;
    logic       row_ge2;
  } win_ctl_t;

  typedef struct packed {
    div_kind_t kind;
    logic      last;
  } emit_ctl_t;

endpackage

// File: design/bb3c_ram.sv
module bb3c_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/bb3c_window.sv
module bb3c_window #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16,
  localparam int AW          = $clog2(MAX_SIZE)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  logic [2:0][CHANNEL_BITS-1:0]        in_pix,
  input  logic                                cfg_fire,
  input  logic [bb3c_pkg::SIZE_W-1:0]         cfg_size,
  output logic [8:0][2:0][CHANNEL_BITS-1:0]   blk,
  output logic [AW-1:0]                       row,
  output logic [AW-1:0]                       col,
  output bb3c_pkg::win_ctl_t                  ctl
);

  import bb3c_pkg::*;

  localparam int SZW      = $clog2(MAX_SIZE + 1);
  localparam int PW       = 3 * CHANNEL_BITS;
  localparam int RST_SIZE = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;

  logic [AW-1:0]                     row_r, row_nxt;
  logic [AW-1:0]                     col_r, col_nxt;
  logic [SZW-1:0]                    size_r, size_nxt;
  logic [5:0][2:0][CHANNEL_BITS-1:0] win_r, win_nxt;
  logic [PW-1:0]                     upper_rd, middle_rd;
  logic                              last_col, last_row;

  assign last_col = SZW'(col_r) == size_r - SZW'(1);
  assign last_row = SZW'(row_r) == size_r - SZW'(1);

  always_comb begin
    size_nxt = size_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cfg_fire) begin
      if (cfg_size < SIZE_W'(2)) begin
        size_nxt = SZW'(2);
      end else if (32'(cfg_size) > 32'(MAX_SIZE)) begin
        size_nxt = SZW'(MAX_SIZE);
      end else begin
        size_nxt = SZW'(cfg_size);
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZW'(RST_SIZE);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      size_r <= size_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // Read ahead at the next column so the data is waiting for the next pixel
  bb3c_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_SIZE)
  ) u_upper (
    .clk  (clk),
    .we   (in_fire),
    .waddr(col_r),
    .wdata(middle_rd),
    .raddr(col_nxt),
    .rdata(upper_rd)
  );

  bb3c_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_SIZE)
  ) u_middle (
    .clk  (clk),
    .we   (in_fire),
    .waddr(col_r),
    .wdata(in_pix),
    .raddr(col_nxt),
    .rdata(middle_rd)
  );

  always_comb begin
    blk[5:0] = win_r;
    blk[6]   = upper_rd;
    blk[7]   = middle_rd;
    blk[8]   = in_pix;
  end

  assign win_nxt[2:0] = win_r[5:3];
  assign win_nxt[5:3] = blk[8:6];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    ctl                    = '0;
    ctl.emit[EMIT_UP_LEFT] = (row_r != '0) && (col_r != '0);
    ctl.emit[EMIT_UP]      = (row_r != '0) && last_col;
    ctl.emit[EMIT_LEFT]    = last_row && (col_r != '0);
    ctl.emit[EMIT_HERE]    = last_row && last_col;
    ctl.col_ge2            = col_r > AW'(1);
    ctl.row_ge2            = row_r > AW'(1);
  end

  assign row = row_r;
  assign col = col_r;

  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (SZW'(col_r) < size_r) && (SZW'(row_r) < size_r))
    else $error("pixel position outside the image");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r >= SZW'(2)) && (32'(size_r) <= 32'(MAX_SIZE)))
    else $error("image size out of range");

endmodule

// File: design/bb3c_emit.sv
module bb3c_emit #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16,
  localparam int AW          = $clog2(MAX_SIZE),
  localparam int SW          = CHANNEL_BITS + 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [8:0][2:0][CHANNEL_BITS-1:0] blk,
  input  logic [AW-1:0]                     row,
  input  logic [AW-1:0]                     col,
  input  bb3c_pkg::win_ctl_t                ctl,
  output logic                              s_valid,
  input  logic                              s_ready,
  output logic [2:0][SW-1:0]                s_sum,
  output logic [AW-1:0]                     s_row,
  output logic [AW-1:0]                     s_col,
  output bb3c_pkg::emit_ctl_t               s_ctl
);

  import bb3c_pkg::*;

  logic [8:0][2:0][CHANNEL_BITS-1:0] blk_r;
  logic [AW-1:0]                     row_r, col_r;
  logic                              col_ge2_r, row_ge2_r;
  logic [3:0]                        pend_r, pend_nxt;
  logic [3:0]                        sel;
  logic                              here_col, here_row;
  logic [2:0]                        col_mask, row_mask;
  logic [2:0][SW-1:0]                sum;
  emit_ctl_t                         sel_ctl;
  logic                              s_free, emit_go, in_fire;
  logic                              s_valid_r, s_valid_nxt;
  logic [2:0][SW-1:0]                s_sum_r;
  logic [AW-1:0]                     s_row_r, s_col_r;
  emit_ctl_t                         s_ctl_r;

  assign sel      = pend_r & (~pend_r + 4'd1);
  assign here_col = sel[EMIT_UP] | sel[EMIT_HERE];
  assign here_row = sel[EMIT_LEFT] | sel[EMIT_HERE];
  assign col_mask = {2'b11, ~here_col & col_ge2_r};
  assign row_mask = {2'b11, ~here_row & row_ge2_r};

  assign s_free   = !s_valid_r || s_ready;
  assign emit_go  = (pend_r != '0) && s_free;
  assign in_ready = (pend_r == '0) || (s_free && ((pend_r & ~sel) == '0));
  assign in_fire  = in_valid && in_ready;

  always_comb begin : sum_window
    logic [2:0][SW-1:0] part;
    part = '0;
    for (int k = 0; k < 3; k++) begin
      for (int dc = 0; dc < 3; dc++) begin
        part[dc] = ((col_mask[dc] && row_mask[0]) ? SW'(blk_r[dc*3][k])   : '0)
                 + ((col_mask[dc] && row_mask[1]) ? SW'(blk_r[dc*3+1][k]) : '0)
                 + ((col_mask[dc] && row_mask[2]) ? SW'(blk_r[dc*3+2][k]) : '0);
      end
      sum[k] = part[0] + part[1] + part[2];
    end
  end

  always_comb begin
    sel_ctl.last = (pend_r & ~sel) == '0;
    unique case ({col_mask[0], row_mask[0]})
      2'b11:        sel_ctl.kind = DIV_BY_9;
      2'b10, 2'b01: sel_ctl.kind = DIV_BY_6;
      2'b00:        sel_ctl.kind = DIV_BY_4;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_fire) begin
      pend_nxt = ctl.emit;
    end else if (emit_go) begin
      pend_nxt = pend_r & ~sel;
    end
  end

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (emit_go) begin
      s_valid_nxt = 1'b1;
    end else if (s_ready) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      s_valid_r <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blk_r     <= blk;
      row_r     <= row;
      col_r     <= col;
      col_ge2_r <= ctl.col_ge2;
      row_ge2_r <= ctl.row_ge2;
    end
    if (emit_go) begin
      s_sum_r <= sum;
      s_row_r <= here_row ? row_r : row_r - AW'(1);
      s_col_r <= here_col ? col_r : col_r - AW'(1);
      s_ctl_r <= sel_ctl;
    end
  end

  assign s_valid = s_valid_r;
  assign s_sum   = s_sum_r;
  assign s_row   = s_row_r;
  assign s_col   = s_col_r;
  assign s_ctl   = s_ctl_r;

  a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ctl.emit[EMIT_HERE] |-> ctl.emit[EMIT_LEFT])
    else $error("final result loaded without the one before it");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) && !s_free |=> pend_r == $past(pend_r))
    else $error("pending results changed while the sum stage was full");

  a_sum_fill: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> s_valid_r)
    else $error("issued result missing from the sum stage");

endmodule

// File: design/bb3c_div.sv
module bb3c_div #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16,
  localparam int AW          = $clog2(MAX_SIZE),
  localparam int SW          = CHANNEL_BITS + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [2:0][SW-1:0]            s_sum,
  input  logic [AW-1:0]                 s_row,
  input  logic [AW-1:0]                 s_col,
  input  bb3c_pkg::emit_ctl_t           s_ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_red,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_green,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_blue,
  output logic [bb3c_pkg::POS_W-1:0]    out_row,
  output logic [bb3c_pkg::POS_W-1:0]    out_col,
  output logic                          out_run_last
);

  import bb3c_pkg::*;

  localparam int MW  = SW + 1;
  localparam int PRW = SW + MW;
  localparam int K6  = SW + 3;
  localparam int K9  = SW + 4;
  localparam int M6  = (2**K6 + 5) / 6;
  localparam int M9  = (2**K9 + 8) / 9;

  logic [MW-1:0]                   mult;
  logic [2:0][PRW-1:0]             prod;
  logic [2:0][CHANNEL_BITS-1:0]    quo;
  logic                            out_valid_r, out_valid_nxt;
  logic [2:0][CHANNEL_BITS-1:0]    quo_r;
  logic [AW-1:0]                   row_r, col_r;
  logic                            last_r;
  logic                            s_fire;

  assign s_ready = !out_valid_r || out_ready;
  assign s_fire  = s_valid && s_ready;

  // Divide by reciprocal multiply; exact over the full sum range
  assign mult = (s_ctl.kind == DIV_BY_9) ? MW'(M9) : MW'(M6);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PRW'(s_sum[k]) * PRW'(mult);
      unique case (s_ctl.kind)
        DIV_BY_4: quo[k] = CHANNEL_BITS'(s_sum[k] >> 2);
        DIV_BY_6: quo[k] = CHANNEL_BITS'(prod[k] >> K6);
        DIV_BY_9: quo[k] = CHANNEL_BITS'(prod[k] >> K9);
        default:  quo[k] = CHANNEL_BITS'(s_sum[k] >> 2);
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      quo_r  <= quo;
      row_r  <= s_row;
      col_r  <= s_col;
      last_r <= s_ctl.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = CHAN_W'(quo_r[0]);
  assign out_green    = CHAN_W'(quo_r[1]);
  assign out_blue     = CHAN_W'(quo_r[2]);
  assign out_row      = POS_W'(row_r);
  assign out_col      = POS_W'(col_r);
  assign out_run_last = last_r;

endmodule

// File: design/box_blur_3x3_clipped_unit.sv
// 3x3 box blur over a square RGB image streamed in raster order, one pixel per
// transaction, with the window clipped at the image border (mean of 4 pixels at
// a corner, 6 on an edge, 9 inside, truncated). Results are tagged with their
// row and column; out_run_last marks the final result caused by one input pixel.
// A pixel whose results fit the output goes in every clock; a pixel that causes
// several results holds the input while a sequencer issues them one per cycle
// whenever the sum stage is free: the last pixel of each inner row and every
// bottom-row pixel between the first and the last cause two results, the final
// pixel four. The first result of a pixel is registered in the emit stage, then
// in the sum stage, then in the output registers. Two line stores of MAX_SIZE
// pixels, read one column ahead, give the two rows above; they need no clearing,
// as unwritten entries always lie outside the clipped window. A write of the
// image size (clamped to 2..MAX_SIZE) is taken in any cycle and starts a new
// image; a pixel accepted in the same cycle still belongs to the old one.
module box_blur_3x3_clipped_unit #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bb3c_pkg::CHAN_W-1:0]   in_red,
  input  logic [bb3c_pkg::CHAN_W-1:0]   in_green,
  input  logic [bb3c_pkg::CHAN_W-1:0]   in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_red,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_green,
  output logic [bb3c_pkg::CHAN_W-1:0]   out_blue,
  output logic [bb3c_pkg::POS_W-1:0]    out_row,
  output logic [bb3c_pkg::POS_W-1:0]    out_col,
  output logic                          out_run_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3c_pkg::SIZE_W-1:0]   cfg_image_size
);

  import bb3c_pkg::*;

  localparam int AW = $clog2(MAX_SIZE);
  localparam int SW = CHANNEL_BITS + 4;

  logic                              in_fire;
  logic [2:0][CHANNEL_BITS-1:0]      in_pix;
  logic [8:0][2:0][CHANNEL_BITS-1:0] blk;
  logic [AW-1:0]                     row, col;
  win_ctl_t                          ctl;
  logic                              s_valid, s_ready;
  logic [2:0][SW-1:0]                s_sum;
  logic [AW-1:0]                     s_row, s_col;
  emit_ctl_t                         s_ctl;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_pix    = {in_blue[CHANNEL_BITS-1:0], in_green[CHANNEL_BITS-1:0],
                      in_red[CHANNEL_BITS-1:0]};

  bb3c_window #(
    .MAX_SIZE    (MAX_SIZE),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_pix  (in_pix),
    .cfg_fire(cfg_valid),
    .cfg_size(cfg_image_size),
    .blk     (blk),
    .row     (row),
    .col     (col),
    .ctl     (ctl)
  );

  bb3c_emit #(
    .MAX_SIZE    (MAX_SIZE),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .blk     (blk),
    .row     (row),
    .col     (col),
    .ctl     (ctl),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_sum   (s_sum),
    .s_row   (s_row),
    .s_col   (s_col),
    .s_ctl   (s_ctl)
  );

  bb3c_div #(
    .MAX_SIZE    (MAX_SIZE),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_sum       (s_sum),
    .s_row       (s_row),
    .s_col       (s_col),
    .s_ctl       (s_ctl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_run_last(out_run_last)
  );

endmodule
